// File: design/polar_block_encoder_unit_assert.svh
// assertion macros for the polar block encoder
`ifndef POLAR_BLOCK_ENCODER_UNIT_ASSERT_SVH
`define POLAR_BLOCK_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbe check failed");

// next-cycle implication
`define PBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbe check failed");

`endif

// File: design/pbe_pkg.sv
// shared types and constants for the polar block encoder
`timescale 1ns / 1ps
`default_nettype none

package pbe_pkg;

    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd6;

    typedef struct packed {
        logic load;
        logic stage;
        logic emit;
    } pbe_cmd_t;

    typedef struct packed {
        logic len_end;
        logic stage_end;
        logic out_space;
    } pbe_status_t;

endpackage

`default_nettype wire

// File: design/pbe_in_if.sv
// input channel: one info bit per word
`timescale 1ns / 1ps
`default_nettype none

interface pbe_in_if;
    logic valid;
    logic ready;
    logic info_bit;

    modport source (output valid, output info_bit, input ready);
    modport sink (input valid, input info_bit, output ready);
endinterface

`default_nettype wire

// File: design/pbe_out_if.sv
// output channel: one coded bit per word with end-of-block mark
`timescale 1ns / 1ps
`default_nettype none

interface pbe_out_if;
    logic valid;
    logic ready;
    logic coded_bit;
    logic last_of_block;

    modport source (output valid, output coded_bit, output last_of_block, input ready);
    modport sink (input valid, input coded_bit, input last_of_block, output ready);
endinterface

`default_nettype wire

// File: design/polar_block_encoder_unit.sv
// top level of the bit-serial polar block encoder
//
//   port         dir   width  role
//   in_word      sink  1      info bit, index order from zero
//   out_word     src   1+1    coded bit and end-of-block mark
//   cfg_wr_en    in    1      write log2 block length
//   cfg_wr_data  in    3      new log2 block length
//
// one block of L = 2^n bits passes through the load, transform and emit phases
// in turn; the single bit vector holds one block, so blocks do not overlap
// input is taken only in the load phase, one bit per cycle
// a held-off output stalls the emit phase one word at a time
// reset: no block in progress, log2 length 6
`timescale 1ns / 1ps
`default_nettype none

module polar_block_encoder_unit #(
    parameter int MAX_LOG2_LENGTH = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    pbe_in_if.sink                         in_word,
    pbe_out_if.source                      out_word,
    input  wire logic                      cfg_wr_en,
    input  wire logic [pbe_pkg::CFG_W-1:0] cfg_wr_data
);
    import pbe_pkg::*;

    pbe_cmd_t    cmd;
    pbe_status_t status;
    logic        in_ready;

    assign in_word.ready = in_ready;

    pbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_ready),
        .cfg_wr_en (cfg_wr_en),
        .status    (status),
        .cmd       (cmd)
    );

    pbe_datapath #(
        .MAX_LOG2_LENGTH (MAX_LOG2_LENGTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .info_bit      (in_word.info_bit),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_word.valid),
        .out_ready     (out_word.ready),
        .coded_bit     (out_word.coded_bit),
        .last_of_block (out_word.last_of_block)
    );

endmodule

`default_nettype wire

// File: design/pbe_ctrl.sv
// controller state machine: load, transform and emit phases
`timescale 1ns / 1ps
`default_nettype none

`include "polar_block_encoder_unit_assert.svh"

module pbe_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cfg_wr_en,
    input  wire pbe_pkg::pbe_status_t status,
    output pbe_pkg::pbe_cmd_t        cmd
);
    import pbe_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_XFORM,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_LOAD);

    always_comb
    begin
        cmd.load  = in_valid && (state_reg == ST_LOAD);
        cmd.stage = (state_reg == ST_XFORM);
        cmd.emit  = (state_reg == ST_EMIT) && status.out_space;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cmd.load && status.len_end)
                begin
                    state_next = ST_XFORM;
                end
            end
            ST_XFORM:
            begin
                if (status.stage_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit && status.len_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (cfg_wr_en)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PBE_ASSERT_SAME(a_one_cmd, clk, rst_n, 1'b1, !(cmd.load && cmd.emit) && !(cmd.load && cmd.stage))
    `PBE_ASSERT_NEXT(a_xform_to_emit, clk, rst_n, cmd.stage && status.stage_end && !cfg_wr_en, state_reg == ST_EMIT)
    `PBE_ASSERT_NEXT(a_emit_to_load, clk, rst_n, cmd.emit && status.len_end, in_ready)

endmodule

`default_nettype wire

// File: design/pbe_datapath.sv
// bit vector, butterfly stages, shared counter and output register
`timescale 1ns / 1ps
`default_nettype none

module pbe_datapath #(
    parameter int MAX_LOG2_LENGTH = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pbe_pkg::pbe_cmd_t          cmd,
    output pbe_pkg::pbe_status_t            status,
    input  wire logic                       info_bit,
    input  wire logic                       cfg_wr_en,
    input  wire logic [pbe_pkg::CFG_W-1:0]  cfg_wr_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            coded_bit,
    output logic                            last_of_block
);
    import pbe_pkg::*;

    localparam int CW    = MAX_LOG2_LENGTH;
    localparam int NW    = $clog2(MAX_LOG2_LENGTH + 1);
    localparam int L_MAX = 1 << MAX_LOG2_LENGTH;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_LOG2_LENGTH);

    logic [CFG_W-1:0] log2_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [L_MAX-1:0] vec_reg;
    logic [L_MAX-1:0] vec_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             coded_reg;
    logic             coded_next;
    logic             last_reg;
    logic             last_next;

    logic [NW-1:0]    n_eff;
    logic [CW-1:0]    len_m1;
    logic [CW-1:0]    cnt_rev;
    logic [CW-1:0]    wr_idx;
    logic [CW-1:0]    stage_sel;
    logic [L_MAX-1:0] flip;

    // clamp the stage count to 1..max
    always_comb
    begin
        if (log2_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(log2_reg) > MAX_LOG2_LENGTH)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = NW'(log2_reg);
        end
    end

    assign len_m1 = ~({CW{1'b1}} << n_eff);

    always_comb
    begin
        for (int i = 0; i < CW; i++)
        begin
            cnt_rev[i] = cnt_reg[CW-1-i];
        end
    end

    // loading at the bit-reversed slot lets the output shift out in order
    assign wr_idx    = cnt_rev >> (MAX_N - n_eff);
    assign stage_sel = cmd.stage ? (CW'(1) << cnt_reg) : '0;

    for (genvar p = 0; p < L_MAX; p++)
    begin : g_bit
        logic [CW-1:0] terms;
        for (genvar s = 0; s < CW; s++)
        begin : g_stage
            if (((p >> s) % 2) == 0)
            begin : g_upper
                assign terms[s] = stage_sel[s] & vec_reg[p + (1 << s)];
            end
            else
            begin : g_lower
                assign terms[s] = 1'b0;
            end
        end
        assign flip[p] = ^terms;
    end

    always_comb
    begin
        status.len_end   = (cnt_reg == len_m1);
        status.stage_end = (cnt_reg == CW'(n_eff - NW'(1)));
        status.out_space = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        vec_next = vec_reg ^ flip;
        if (cmd.load)
        begin
            vec_next[wr_idx] = info_bit;
        end
        else if (cmd.emit)
        begin
            vec_next = vec_reg >> 1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_wr_en)
        begin
            cnt_next = '0;
        end
        else if (cmd.load || cmd.emit)
        begin
            cnt_next = status.len_end ? '0 : cnt_reg + CW'(1);
        end
        else if (cmd.stage)
        begin
            cnt_next = status.stage_end ? '0 : cnt_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        coded_next     = coded_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            coded_next     = vec_reg[0];
            last_next      = status.len_end;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg      <= CFG_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                log2_reg <= cfg_wr_data;
            end
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg   <= vec_next;
        coded_reg <= coded_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign coded_bit     = coded_reg;
    assign last_of_block = last_reg;

endmodule

`default_nettype wire

// File: test/polar_block_encoder_unit_tb.sv
// self-checking bench for the bit-serial polar block encoder
`timescale 1ns / 1ps

module polar_block_encoder_unit_tb;

    localparam int MAX_LOG2 = 6;
    localparam int MAX_LEN = 1 << MAX_LOG2;
    localparam int SETTLE_CYCLES = 2 * MAX_LEN + MAX_LOG2 + 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        bit coded;
        bit last;
    } coded_word_t;

    class codeword_tracker;
        bit blk [MAX_LEN];
        int unsigned loaded;
        bit [pbe_pkg::CFG_W-1:0] log2_len;
        coded_word_t due [$];
        int mismatches;

        function new();
            log2_len = pbe_pkg::CFG_RESET;
            loaded = 0;
            mismatches = 0;
        endfunction

        function void set_length(bit [pbe_pkg::CFG_W-1:0] v);
            log2_len = v;
            loaded = 0;
        endfunction

        function int unsigned stages();
            if (log2_len < 1)
                return 1;
            if (log2_len > MAX_LOG2)
                return MAX_LOG2;
            return log2_len;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void take_info_bit(bit b);
            int unsigned n;
            int unsigned len;
            int unsigned span;
            int unsigned src;
            coded_word_t w;
            n = stages();
            len = 1 << n;
            if (loaded >= len)
                loaded = 0;
            blk[loaded] = b;
            loaded++;
            if (loaded < len)
                return;
            for (int unsigned s = 0; s < n; s++)
            begin
                span = 1 << s;
                for (int unsigned i = 0; i < len; i++)
                begin
                    if ((i & span) == 0)
                        blk[i] = blk[i] ^ blk[i + span];
                end
            end
            // emission order is bit-reversed index
            for (int unsigned k = 0; k < len; k++)
            begin
                src = 0;
                for (int unsigned j = 0; j < n; j++)
                    src = (src << 1) | ((k >> j) & 1);
                w.coded = blk[src];
                w.last = (k == len - 1);
                due = {due, w};
            end
            loaded = 0;
        endfunction

        function void match_coded_bit(logic c, logic l);
            coded_word_t w;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: coded_bit %b last_of_block %b", c, l);
                return;
            end
            w = due.pop_front();
            if (c !== w.coded || l !== w.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected coded_bit %b last_of_block %b, got %b %b",
                             w.coded, w.last, c, l);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [pbe_pkg::CFG_W-1:0] cfg_wr_data;
    int tx_pct;
    int rx_pct;
    int unsigned cycles;

    pbe_in_if in_bus ();
    pbe_out_if out_bus ();

    codeword_tracker board = new();

    polar_block_encoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_word     (in_bus),
        .out_word    (out_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver side
    initial
    begin
        out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_bus.ready <= ($urandom_range(0, 99) < rx_pct) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            board.match_coded_bit(out_bus.coded_bit, out_bus.last_of_block);
    end

    task automatic send_bit(bit b);
        while ($urandom_range(0, 99) < tx_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.info_bit <= b;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        board.take_info_bit(b);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(bit [pbe_pkg::CFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_length(v);
    endtask

    task automatic send_pattern(bit [31:0] pattern, int count);
        for (int i = 0; i < count; i++)
            send_bit(pattern[i]);
    endtask

    initial
    begin
        bit [pbe_pkg::CFG_W-1:0] phase_len [8];
        int phase_tx [8];
        int phase_rx [8];
        int unsigned len;
        int unsigned blocks;
        int unsigned nbits;

        phase_len = '{3'd7, 3'd4, 3'd1, 3'd3, 3'd0, 3'd5, 3'd2, 3'd4};
        phase_tx = '{0, 49, 0, 21, 0, 49, 0, 21};
        phase_rx = '{0, 0, 49, 21, 0, 0, 49, 21};

        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.info_bit = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        tx_pct = 0;
        rx_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero stages act as one: all four bit pairs
        write_length(3'd0);
        send_pattern(32'b11_01_10_00, 8);
        write_length(3'd1);
        send_pattern(32'b11, 2);
        write_length(3'd2);
        send_pattern(32'b1101, 4);
        // partial block dropped by a length write
        send_pattern(32'b101, 3);
        write_length(3'd3);
        send_pattern(32'b11001011, 8);

        for (int p = 0; p < 8; p++)
        begin
            write_length(phase_len[p]);
            tx_pct = phase_tx[p];
            rx_pct = phase_rx[p];
            len = 1 << board.stages();
            blocks = (len >= 32) ? 1 : (12 + len - 1) / len;
            nbits = blocks * len + $urandom_range(0, 3);
            for (int unsigned b = 0; b < nbits; b++)
            begin
                send_bit(1'($urandom_range(0, 1)));
                if (board.pending() != 0 && $urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
